// ===== design/x86d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86d_pkg
// Types and opcode-pattern decode for the 16-bit x86 instruction decoder.
// ----------------------------------------------------------------------------
package x86d_pkg;

	localparam logic [2:0] FMT_REG_OP   = 3'd0;
	localparam logic [2:0] FMT_SHORT_JMP = 3'd1;
	localparam logic [2:0] FMT_IMM_REG  = 3'd2;
	localparam logic [2:0] FMT_ACC      = 3'd3;
	localparam logic [2:0] FMT_RM_REG   = 3'd4;
	localparam logic [2:0] FMT_IMM_RM   = 3'd5;
	localparam logic [2:0] FMT_UNSUP    = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_UNSUP   = 2'd2;

	localparam logic [5:0] MN_XCHG  = 6'd0;
	localparam logic [5:0] MN_INC   = 6'd1;
	localparam logic [5:0] MN_DEC   = 6'd2;
	localparam logic [5:0] MN_IN    = 6'd3;
	localparam logic [5:0] MN_OUT   = 6'd4;
	localparam logic [5:0] MN_JE    = 6'd5;
	localparam logic [5:0] MN_JL    = 6'd6;
	localparam logic [5:0] MN_JLE   = 6'd7;
	localparam logic [5:0] MN_JB    = 6'd8;
	localparam logic [5:0] MN_JBE   = 6'd9;
	localparam logic [5:0] MN_JP    = 6'd10;
	localparam logic [5:0] MN_JO    = 6'd11;
	localparam logic [5:0] MN_JS    = 6'd12;
	localparam logic [5:0] MN_JNZ   = 6'd13;
	localparam logic [5:0] MN_JNL   = 6'd14;
	localparam logic [5:0] MN_JG    = 6'd15;
	localparam logic [5:0] MN_JNB   = 6'd16;
	localparam logic [5:0] MN_JA    = 6'd17;
	localparam logic [5:0] MN_JNP   = 6'd18;
	localparam logic [5:0] MN_JNO   = 6'd19;
	localparam logic [5:0] MN_JNS   = 6'd20;
	localparam logic [5:0] MN_LOOP  = 6'd21;
	localparam logic [5:0] MN_LOOPZ = 6'd22;
	localparam logic [5:0] MN_LOOPNZ = 6'd23;
	localparam logic [5:0] MN_JCXZ  = 6'd24;
	localparam logic [5:0] MN_MOV   = 6'd25;
	localparam logic [5:0] MN_ADD   = 6'd26;
	localparam logic [5:0] MN_ADC   = 6'd27;
	localparam logic [5:0] MN_SUB   = 6'd28;
	localparam logic [5:0] MN_SBB   = 6'd29;
	localparam logic [5:0] MN_CMP   = 6'd30;
	localparam logic [5:0] MN_XOR   = 6'd31;
	localparam logic [5:0] MN_TEST  = 6'd32;
	localparam logic [5:0] MN_OR    = 6'd33;
	localparam logic [5:0] MN_AND   = 6'd34;
	localparam logic [5:0] MN_GROUP = 6'd63;

	typedef struct packed {
		logic       hit;
		logic [5:0] mn;
		logic [2:0] fmt;
	} op_class_t;

	typedef struct packed {
		logic [5:0]  mnemonic;
		logic [2:0]  format;
		logic        wide;
		logic        dir_or_sign;
		logic [1:0]  mode_bits;
		logic [2:0]  reg_bits;
		logic [2:0]  rm_bits;
		logic signed [15:0] displacement;
		logic signed [15:0] immediate;
		logic        is_mem_address;
		logic [2:0]  length;
		logic [1:0]  status;
	} dec_rec_t;

	function automatic op_class_t classify(input logic [7:0] b);
		op_class_t r;
		r = '{hit: 1'b1, mn: MN_XCHG, fmt: FMT_UNSUP};
		if (b[7:3] == 5'b10010) begin
			r.mn = MN_XCHG; r.fmt = FMT_REG_OP;
		end else if (b[7:3] == 5'b01000) begin
			r.mn = MN_INC; r.fmt = FMT_REG_OP;
		end else if (b[7:3] == 5'b01001) begin
			r.mn = MN_DEC; r.fmt = FMT_REG_OP;
		end else if (b[7:1] == 7'b1110110) begin
			r.mn = MN_IN;
		end else if (b[7:1] == 7'b1110111) begin
			r.mn = MN_OUT;
		end else if (b[7:4] == 4'h7 || b[7:2] == 6'b111000) begin
			r.fmt = FMT_SHORT_JMP;
			case (b)
				8'h74: r.mn = MN_JE;
				8'h7C: r.mn = MN_JL;
				8'h7E: r.mn = MN_JLE;
				8'h72: r.mn = MN_JB;
				8'h76: r.mn = MN_JBE;
				8'h7A: r.mn = MN_JP;
				8'h70: r.mn = MN_JO;
				8'h78: r.mn = MN_JS;
				8'h75: r.mn = MN_JNZ;
				8'h7D: r.mn = MN_JNL;
				8'h7F: r.mn = MN_JG;
				8'h73: r.mn = MN_JNB;
				8'h77: r.mn = MN_JA;
				8'h7B: r.mn = MN_JNP;
				8'h71: r.mn = MN_JNO;
				8'h79: r.mn = MN_JNS;
				8'hE2: r.mn = MN_LOOP;
				8'hE1: r.mn = MN_LOOPZ;
				8'hE0: r.mn = MN_LOOPNZ;
				8'hE3: r.mn = MN_JCXZ;
				default: r.mn = MN_XCHG;
			endcase
		end else if (b[7:1] == 7'b1110010) begin
			r.mn = MN_IN;
		end else if (b[7:1] == 7'b1110011) begin
			r.mn = MN_OUT;
		end else if (b[7:1] == 7'b1010000 || b[7:1] == 7'b1010001) begin
			r.mn = MN_MOV; r.fmt = FMT_ACC;
		end else if (b[7:1] == 7'b0000010) begin
			r.mn = MN_ADD; r.fmt = FMT_ACC;
		end else if (b[7:1] == 7'b0001010) begin
			r.mn = MN_ADC; r.fmt = FMT_ACC;
		end else if (b[7:1] == 7'b0010110) begin
			r.mn = MN_SUB; r.fmt = FMT_ACC;
		end else if (b[7:1] == 7'b0001110) begin
			r.mn = MN_SBB; r.fmt = FMT_ACC;
		end else if (b[7:1] == 7'b0011110) begin
			r.mn = MN_CMP; r.fmt = FMT_ACC;
		end else if (b[7:4] == 4'hB) begin
			r.mn = MN_MOV; r.fmt = FMT_IMM_REG;
		end else if (b[7:2] == 6'b100010) begin
			r.mn = MN_MOV; r.fmt = FMT_RM_REG;
		end else if (b[7:1] == 7'b1000011) begin
			r.mn = MN_XCHG; r.fmt = FMT_RM_REG;
		end else if (b[7:2] == 6'b000000) begin
			r.mn = MN_ADD; r.fmt = FMT_RM_REG;
		end else if (b[7:2] == 6'b001010) begin
			r.mn = MN_SUB; r.fmt = FMT_RM_REG;
		end else if (b[7:2] == 6'b001110) begin
			r.mn = MN_CMP; r.fmt = FMT_RM_REG;
		end else if (b[7:1] == 7'b0011010) begin
			r.mn = MN_XOR;
		end else if (b[7:1] == 7'b1100011) begin
			r.mn = MN_MOV; r.fmt = FMT_IMM_RM;
		end else if (b[7:1] == 7'b1111011) begin
			r.mn = MN_TEST; r.fmt = FMT_IMM_RM;
		end else if (b[7:2] == 6'b100000) begin
			r.mn = MN_GROUP; r.fmt = FMT_IMM_RM;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [5:0] group_mn(input logic [2:0] sub);
		logic [5:0] m;
		case (sub)
			3'd0: m = MN_ADD;
			3'd1: m = MN_OR;
			3'd2: m = MN_ADC;
			3'd3: m = MN_SBB;
			3'd4: m = MN_AND;
			3'd5: m = MN_SUB;
			3'd6: m = MN_XOR;
			default: m = MN_CMP;
		endcase
		return m;
	endfunction

	function automatic logic [15:0] sx8(input logic [7:0] b);
		return {{8{b[7]}}, b};
	endfunction

endpackage

// ===== design/x86d_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86d_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface x86d_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/x86_16bit_instruction_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder
// Byte-stream decoder for a subset of 16-bit x86 machine code.
// ----------------------------------------------------------------------------
// One code byte is taken per cycle while in_ch.ready is high. Bytes collect
// in a six-entry buffer; the byte that completes an instruction produces one
// record, registered in an output register, and the next byte may be taken
// as long as the output register is free or being drained. Decode of the
// first byte, the mod/rm byte and the length is combinational, from the
// buffer plus the incoming byte. After an unknown or unsupported opcode the
// error record is delivered and all later bytes are dropped until reset.
// Jump targets are start + 2 + offset modulo 2^ADDR_BITS, cut to 16 bits.
module x86_16bit_instruction_decoder #(
	parameter int ADDR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	x86d_stream_if.sink   in_ch,
	x86d_stream_if.source out_ch
);

	logic [7:0]           buf_q [6];
	logic [2:0]           held_q;
	logic [ADDR_BITS-1:0] pos_q;
	logic                 halted_q;
	logic                 ovalid_q;
	x86d_pkg::dec_rec_t   rec_q;

	logic [7:0] nb [6];
	logic [2:0] nheld;
	logic [2:0] widx;
	x86d_pkg::op_class_t cls;
	x86d_pkg::dec_rec_t  rec;
	logic       emit, is_err;
	logic [2:0] need, dsz, dat;
	logic [ADDR_BITS-1:0] tgt;
	logic       acc;

	assign in_ch.ready = halted_q || !ovalid_q || out_ch.ready;
	assign acc = in_ch.valid && in_ch.ready && !halted_q;
	assign widx = (held_q >= 3'd6) ? 3'd0 : held_q;
	assign nheld = widx + 3'd1;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			nb[i] = (3'(i) == widx) ? in_ch.data : buf_q[i];
		end
	end

	always_comb begin
		cls = x86d_pkg::classify(nb[0]);
		rec = '0;
		emit = 1'b0;
		is_err = 1'b0;
		need = 3'd1;
		dsz = 3'd0;
		dat = 3'd0;
		tgt = pos_q + ADDR_BITS'(2) + {{(ADDR_BITS-8){nb[1][7]}}, nb[1]};
		rec.mnemonic = cls.mn;
		rec.format = cls.fmt;
		rec.wide = nb[0][0];
		if (!cls.hit) begin
			rec = '0;
			rec.length = 3'd1;
			rec.status = x86d_pkg::ST_UNKNOWN;
			emit = 1'b1;
			is_err = 1'b1;
		end else if (cls.fmt == x86d_pkg::FMT_UNSUP) begin
			rec = '0;
			rec.mnemonic = cls.mn;
			rec.length = 3'd1;
			rec.status = x86d_pkg::ST_UNSUP;
			emit = 1'b1;
			is_err = 1'b1;
		end else begin
			case (cls.fmt)
				x86d_pkg::FMT_REG_OP: begin
					need = 3'd1;
					rec.wide = 1'b1;
					rec.reg_bits = nb[0][2:0];
				end
				x86d_pkg::FMT_SHORT_JMP: begin
					need = 3'd2;
					rec.wide = 1'b0;
					rec.immediate = 16'(tgt);
				end
				x86d_pkg::FMT_IMM_REG: begin
					rec.wide = nb[0][3];
					need = nb[0][3] ? 3'd3 : 3'd2;
					rec.reg_bits = nb[0][2:0];
					rec.immediate = nb[0][3] ? {nb[2], nb[1]} : x86d_pkg::sx8(nb[1]);
				end
				x86d_pkg::FMT_ACC: begin
					rec.is_mem_address = (nb[0][7:2] == 6'b101000);
					need = (rec.is_mem_address || nb[0][0]) ? 3'd3 : 3'd2;
					rec.dir_or_sign = ~nb[0][1];
					rec.immediate = (need == 3'd3) ? {nb[2], nb[1]}
						: x86d_pkg::sx8(nb[1]);
				end
				default: begin
					rec.mode_bits = nb[1][7:6];
					rec.reg_bits = nb[1][5:3];
					rec.rm_bits = nb[1][2:0];
					rec.dir_or_sign = nb[0][1];
					if (nb[1][7:6] == 2'd1) begin
						dsz = 3'd1;
					end else if (nb[1][7:6] == 2'd2 ||
							(nb[1][7:6] == 2'd0 && nb[1][2:0] == 3'd6)) begin
						dsz = 3'd2;
					end
					if (dsz == 3'd1) begin
						rec.displacement = x86d_pkg::sx8(nb[2]);
					end else if (dsz == 3'd2) begin
						rec.displacement = {nb[3], nb[2]};
					end
					if (cls.fmt == x86d_pkg::FMT_RM_REG) begin
						need = 3'd2 + dsz;
					end else begin
						if (cls.mn == x86d_pkg::MN_MOV || cls.mn == x86d_pkg::MN_TEST) begin
							dat = 3'd1 + {2'd0, nb[0][0]};
						end else begin
							dat = 3'd1 + {2'd0, nb[0][0] & ~nb[0][1]};
						end
						need = 3'd2 + dsz + dat;
						case (dsz)
							3'd0: rec.immediate = (dat == 3'd2) ? {nb[3], nb[2]}
								: x86d_pkg::sx8(nb[2]);
							3'd1: rec.immediate = (dat == 3'd2) ? {nb[4], nb[3]}
								: x86d_pkg::sx8(nb[3]);
							default: rec.immediate = (dat == 3'd2) ? {nb[5], nb[4]}
								: x86d_pkg::sx8(nb[4]);
						endcase
						if (cls.mn == x86d_pkg::MN_GROUP) begin
							rec.mnemonic = x86d_pkg::group_mn(nb[1][5:3]);
						end
					end
				end
			endcase
			rec.length = need;
			emit = (nheld >= need) &&
				!(cls.fmt >= x86d_pkg::FMT_RM_REG && nheld < 3'd2);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[widx] <= in_ch.data;
		end
		if (acc && emit) begin
			rec_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q <= '0;
			halted_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (acc) begin
				if (emit) begin
					held_q <= '0;
					ovalid_q <= 1'b1;
					if (is_err) begin
						halted_q <= 1'b1;
					end else begin
						pos_q <= pos_q + ADDR_BITS'(need);
					end
				end else begin
					held_q <= nheld;
				end
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = rec_q;

endmodule
